[hw/rtl/jmw_pkg.sv]
// jmw_pkg: shared types and constants of the jacobian measure weight core
// used by jmw_sqrt_stage, jacobian_measure_weight_core and jmw_checker
`default_nettype none

package jmw_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DET_SHIFT = 2 * FRAC_BITS;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_KIND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd1;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_CELL = 2'd1;
	localparam logic [1:0] KIND_FACE = 2'd2;
	localparam logic [1:0] KIND_EDGE = 2'd3;

	localparam logic [1:0] PATH_ZERO = 2'd0;
	localparam logic [1:0] PATH_DET = 2'd1;
	localparam logic [1:0] PATH_GRAM = 2'd2;
	localparam logic [1:0] PATH_NORM = 2'd3;

	localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN = 32'h8000_0000;

	localparam int RAD_W = 64;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 3;
	localparam int SQ_STEPS = 4;
	localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

	typedef struct packed {
		logic signed [31:0] j00;
		logic signed [31:0] j01;
		logic signed [31:0] j02;
		logic signed [31:0] j10;
		logic signed [31:0] j11;
		logic signed [31:0] j12;
		logic signed [31:0] j20;
		logic signed [31:0] j21;
		logic signed [31:0] j22;
	} jac_t;

	typedef struct packed {
		logic signed [31:0] weight;
		logic [1:0]         active_columns;
		logic               saturated;
	} res_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_state_t;

	typedef struct packed {
		logic        use_root;
		logic [31:0] w;
		logic [1:0]  n;
		logic        sat;
	} sq_tag_t;

endpackage

`default_nettype wire

[hw/rtl/jmw_sqrt_stage.sv]
// jmw_sqrt_stage: one registered stage of the digit-by-digit integer square root
// depends on jmw_pkg
`default_nettype none

module jmw_sqrt_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                v_in,
	input  wire jmw_pkg::sq_state_t  st_in,
	input  wire jmw_pkg::sq_tag_t    tag_in,
	output logic                     v_out,
	output jmw_pkg::sq_state_t       st_out,
	output jmw_pkg::sq_tag_t         tag_out
);

	jmw_pkg::sq_state_t st_d;
	jmw_pkg::sq_state_t st_q;
	jmw_pkg::sq_tag_t   tag_q;
	logic               v_q;

	always_comb begin
		logic [jmw_pkg::REM_W-1:0] trial;
		st_d = st_in;
		trial = '0;
		for (int i = 0; i < jmw_pkg::SQ_STEPS; i++) begin
			st_d.rem = {st_d.rem[jmw_pkg::REM_W-3:0], st_d.rad[jmw_pkg::RAD_W-1 -: 2]};
			st_d.rad = {st_d.rad[jmw_pkg::RAD_W-3:0], 2'b00};
			trial = {1'b0, st_d.root, 2'b01};
			if (st_d.rem >= trial) begin
				st_d.rem = st_d.rem - trial;
				st_d.root = {st_d.root[jmw_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				st_d.root = {st_d.root[jmw_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= st_d;
			tag_q <= tag_in;
		end
	end

	assign v_out = v_q;
	assign st_out = st_q;
	assign tag_out = tag_q;

endmodule

`default_nettype wire

[hw/rtl/jacobian_measure_weight_core.sv]
// jacobian_measure_weight_core: integration weight of a 3x3 Q16.16 jacobian
// depends on jmw_pkg and jmw_sqrt_stage
//
// usage:
//   request channel jac_valid / jac_stall / jac carries the nine jacobian
//   entries; a request is taken when jac_valid is high and jac_stall is low
//   result channel res_valid / res_stall / res carries weight, active column
//   count and saturation flag; one result per request, in request order
//   config channel cfg_valid / cfg_ready / cfg_index / cfg_data writes
//   geometry_kind (index 0) and zero_threshold (index 1); cfg_ready is always
//   high; write only while no request is in flight, the core does not check
// pipeline: a request passes 8 arithmetic stages, 8 square root stages of
//   4 digits each and the output register before its result shows on res
// throughput: one request per cycle while jac_stall is low, set by the fully
//   pipelined multipliers and root stages
// reset: pipeline empties, geometry_kind returns to cell, threshold to zero
// stall: a stalled result holds; stages behind it keep filling bubbles, and
//   jac_stall rises only once every stage holds a request
`default_nettype none

module jacobian_measure_weight_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              jac_valid,
	output logic                                   jac_stall,
	input  wire jmw_pkg::jac_t                     jac,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output jmw_pkg::res_t                          res,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [jmw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [jmw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration
	logic [1:0]  kind_q;
	logic [30:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= jmw_pkg::KIND_CELL;
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jmw_pkg::REG_GEOMETRY_KIND: kind_q <= cfg_data[1:0];
				jmw_pkg::REG_ZERO_THRESHOLD: thr_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_o;
	logic                sq_v   [jmw_pkg::SQ_STAGES+1];
	jmw_pkg::sq_state_t  sq_st  [jmw_pkg::SQ_STAGES+1];
	jmw_pkg::sq_tag_t    sq_tag [jmw_pkg::SQ_STAGES+1];
	logic                sq_en  [jmw_pkg::SQ_STAGES+1];

	assign en_o = !res_valid || !res_stall;
	assign en_s8 = !v_s8 || sq_en[1];
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign jac_stall = !en_s1;
	assign sq_en[0] = en_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= jac_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// s1: input register
	logic signed [31:0] j_s1 [9];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			j_s1[0] <= jac.j00;
			j_s1[1] <= jac.j01;
			j_s1[2] <= jac.j02;
			j_s1[3] <= jac.j10;
			j_s1[4] <= jac.j11;
			j_s1[5] <= jac.j12;
			j_s1[6] <= jac.j20;
			j_s1[7] <= jac.j21;
			j_s1[8] <= jac.j22;
		end
	end

	// s2: column activity, column select, 2x2 products
	logic [31:0]        mag [9];
	logic [2:0]         act;
	logic [1:0]         cnt;
	logic [1:0]         sel_a, sel_b;
	logic [1:0]         path_d2, n_d2;
	logic signed [31:0] ca_d2 [3];
	logic signed [31:0] cb_d2 [3];
	logic signed [63:0] p_d2 [6];

	always_comb begin
		logic [3:0] ia;
		logic [3:0] ib;
		for (int i = 0; i < 9; i++) begin
			mag[i] = j_s1[i][31] ? (~$unsigned(j_s1[i]) + 32'd1) : $unsigned(j_s1[i]);
		end
		for (int c = 0; c < 3; c++) begin
			act[c] = (mag[c] > {1'b0, thr_q}) || (mag[3+c] > {1'b0, thr_q})
				|| (mag[6+c] > {1'b0, thr_q});
		end
		cnt = {1'b0, act[0]} + {1'b0, act[1]} + {1'b0, act[2]};
		priority if (act[0]) sel_a = 2'd0;
		else if (act[1]) sel_a = 2'd1;
		else sel_a = 2'd2;
		sel_b = (act[0] && act[1]) ? 2'd1 : 2'd2;
		unique case (kind_q)
			jmw_pkg::KIND_POINT: begin
				path_d2 = jmw_pkg::PATH_ZERO;
				n_d2 = 2'd0;
			end
			jmw_pkg::KIND_CELL: begin
				path_d2 = jmw_pkg::PATH_DET;
				n_d2 = 2'd3;
			end
			jmw_pkg::KIND_FACE, jmw_pkg::KIND_EDGE: begin
				n_d2 = cnt;
				unique case (cnt)
					2'd3: path_d2 = jmw_pkg::PATH_DET;
					2'd2: path_d2 = jmw_pkg::PATH_GRAM;
					2'd1: path_d2 = jmw_pkg::PATH_NORM;
					default: path_d2 = jmw_pkg::PATH_ZERO;
				endcase
			end
		endcase
		for (int r = 0; r < 3; r++) begin
			ia = 4'(r * 3) + {2'b00, sel_a};
			ib = 4'(r * 3) + {2'b00, sel_b};
			ca_d2[r] = j_s1[ia];
			cb_d2[r] = j_s1[ib];
		end
		p_d2[0] = j_s1[4] * j_s1[8];
		p_d2[1] = j_s1[5] * j_s1[7];
		p_d2[2] = j_s1[3] * j_s1[8];
		p_d2[3] = j_s1[5] * j_s1[6];
		p_d2[4] = j_s1[3] * j_s1[7];
		p_d2[5] = j_s1[4] * j_s1[6];
	end

	logic [1:0]         path_s2, n_s2;
	logic signed [31:0] ca_s2 [3];
	logic signed [31:0] cb_s2 [3];
	logic signed [31:0] r0_s2 [3];
	logic signed [63:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			path_s2 <= path_d2;
			n_s2 <= n_d2;
			ca_s2 <= ca_d2;
			cb_s2 <= cb_d2;
			r0_s2[0] <= j_s1[0];
			r0_s2[1] <= j_s1[1];
			r0_s2[2] <= j_s1[2];
			p_s2 <= p_d2;
		end
	end

	// s3: minors and gram products
	logic [1:0]         path_s3, n_s3;
	logic signed [31:0] r0_s3 [3];
	logic signed [64:0] m_s3 [3];
	logic signed [63:0] aa_s3 [3];
	logic signed [63:0] bb_s3 [3];
	logic signed [63:0] ab_s3 [3];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			path_s3 <= path_s2;
			n_s3 <= n_s2;
			r0_s3 <= r0_s2;
			for (int c = 0; c < 3; c++) begin
				m_s3[c] <= $signed({p_s2[2*c][63], p_s2[2*c]})
					- $signed({p_s2[2*c+1][63], p_s2[2*c+1]});
				aa_s3[c] <= ca_s2[c] * ca_s2[c];
				bb_s3[c] <= cb_s2[c] * cb_s2[c];
				ab_s3[c] <= ca_s2[c] * cb_s2[c];
			end
		end
	end

	// s4: minor times first row split in halves, gram sums
	logic [1:0]         path_s4, n_s4;
	logic signed [64:0] pl_s4 [3];
	logic signed [64:0] ph_s4 [3];
	logic [63:0]        e_s4, g_s4;
	logic signed [65:0] f_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			path_s4 <= path_s3;
			n_s4 <= n_s3;
			for (int c = 0; c < 3; c++) begin
				pl_s4[c] <= $signed({1'b0, m_s3[c][31:0]}) * r0_s3[c];
				ph_s4[c] <= $signed(m_s3[c][64:32]) * r0_s3[c];
			end
			e_s4 <= $unsigned(aa_s3[0]) + $unsigned(aa_s3[1]) + $unsigned(aa_s3[2]);
			g_s4 <= $unsigned(bb_s3[0]) + $unsigned(bb_s3[1]) + $unsigned(bb_s3[2]);
			f_s4 <= 66'(ab_s3[0]) + 66'(ab_s3[1]) + 66'(ab_s3[2]);
		end
	end

	// s5: determinant terms, |F|, norm overflow
	logic [1:0]         path_s5, n_s5;
	logic signed [96:0] t_s5 [3];
	logic [63:0]        e_s5, g_s5, fm_s5;
	logic               nsat_s5;
	logic signed [65:0] fneg;

	assign fneg = -f_s4;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			path_s5 <= path_s4;
			n_s5 <= n_s4;
			for (int c = 0; c < 3; c++) begin
				t_s5[c] <= $signed({ph_s4[c], 32'd0}) + pl_s4[c];
			end
			e_s5 <= e_s4;
			g_s5 <= g_s4;
			fm_s5 <= f_s4[65] ? fneg[63:0] : f_s4[63:0];
			nsat_s5 <= (e_s4[63:62] != 2'b00);
		end
	end

	// s6: determinant sum, partial products of E*G and F*F
	logic [1:0]         path_s6, n_s6;
	logic signed [98:0] d_s6;
	logic [63:0]        eg_ll_s6, eg_lh_s6, eg_hl_s6, eg_hh_s6;
	logic [63:0]        ff_ll_s6, ff_lh_s6, ff_hh_s6;
	logic [63:0]        e_s6;
	logic               nsat_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			path_s6 <= path_s5;
			n_s6 <= n_s5;
			d_s6 <= 99'(t_s5[0]) - 99'(t_s5[1]) + 99'(t_s5[2]);
			eg_ll_s6 <= e_s5[31:0] * g_s5[31:0];
			eg_lh_s6 <= e_s5[31:0] * g_s5[63:32];
			eg_hl_s6 <= e_s5[63:32] * g_s5[31:0];
			eg_hh_s6 <= e_s5[63:32] * g_s5[63:32];
			ff_ll_s6 <= fm_s5[31:0] * fm_s5[31:0];
			ff_lh_s6 <= fm_s5[31:0] * fm_s5[63:32];
			ff_hh_s6 <= fm_s5[63:32] * fm_s5[63:32];
			e_s6 <= e_s5;
			nsat_s6 <= nsat_s5;
		end
	end

	// s7: determinant floor and clamp, wide products assembled
	logic [1:0]   path_s7, n_s7;
	logic [31:0]  dw_s7;
	logic         dsat_s7;
	logic [127:0] eg_s7, ff_s7;
	logic [63:0]  e_s7;
	logic         nsat_s7;
	logic         d_fits;

	assign d_fits = (d_s6[98:jmw_pkg::DET_SHIFT+31] == '0)
		|| (d_s6[98:jmw_pkg::DET_SHIFT+31] == '1);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			path_s7 <= path_s6;
			n_s7 <= n_s6;
			dsat_s7 <= !d_fits;
			if (d_fits) begin
				dw_s7 <= d_s6[jmw_pkg::DET_SHIFT+31:jmw_pkg::DET_SHIFT];
			end else begin
				dw_s7 <= d_s6[98] ? jmw_pkg::W_MIN : jmw_pkg::W_MAX;
			end
			eg_s7 <= {eg_hh_s6, 64'd0} + {32'd0, eg_lh_s6, 32'd0}
				+ {32'd0, eg_hl_s6, 32'd0} + {64'd0, eg_ll_s6};
			ff_s7 <= {ff_hh_s6, 64'd0} + {31'd0, ff_lh_s6, 33'd0} + {64'd0, ff_ll_s6};
			e_s7 <= e_s6;
			nsat_s7 <= nsat_s6;
		end
	end

	// s8: gram radicand, root request set up
	logic [127:0]       dg, gsh;
	logic               gsat;
	jmw_pkg::sq_state_t st_d8;
	jmw_pkg::sq_tag_t   tag_d8;
	jmw_pkg::sq_state_t st_s8;
	jmw_pkg::sq_tag_t   tag_s8;

	always_comb begin
		dg = eg_s7 - ff_s7;
		gsh = dg >> jmw_pkg::DET_SHIFT;
		gsat = (gsh[127:62] != '0);
		st_d8.rem = '0;
		st_d8.root = '0;
		st_d8.rad = '0;
		tag_d8.n = n_s7;
		tag_d8.use_root = 1'b0;
		tag_d8.w = '0;
		tag_d8.sat = 1'b0;
		unique case (path_s7)
			jmw_pkg::PATH_DET: begin
				tag_d8.w = dw_s7;
				tag_d8.sat = dsat_s7;
			end
			jmw_pkg::PATH_GRAM: begin
				tag_d8.sat = gsat;
				tag_d8.use_root = !gsat;
				tag_d8.w = gsat ? jmw_pkg::W_MAX : 32'd0;
				st_d8.rad = {2'b00, gsh[61:0]};
			end
			jmw_pkg::PATH_NORM: begin
				tag_d8.sat = nsat_s7;
				tag_d8.use_root = !nsat_s7;
				tag_d8.w = nsat_s7 ? jmw_pkg::W_MAX : 32'd0;
				st_d8.rad = {2'b00, e_s7[61:0]};
			end
			jmw_pkg::PATH_ZERO: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			st_s8 <= st_d8;
			tag_s8 <= tag_d8;
		end
	end

	// square root stages
	assign sq_v[0] = v_s8;
	assign sq_st[0] = st_s8;
	assign sq_tag[0] = tag_s8;

	for (genvar g = 0; g < jmw_pkg::SQ_STAGES; g++) begin : g_sq
		jmw_sqrt_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (sq_en[g+1]),
			.v_in    (sq_v[g]),
			.st_in   (sq_st[g]),
			.tag_in  (sq_tag[g]),
			.v_out   (sq_v[g+1]),
			.st_out  (sq_st[g+1]),
			.tag_out (sq_tag[g+1])
		);
		if (g == jmw_pkg::SQ_STAGES - 1) begin : g_last
			assign sq_en[g+1] = !sq_v[g+1] || en_o;
		end else begin : g_mid
			assign sq_en[g+1] = !sq_v[g+1] || sq_en[g+2];
		end
	end

	// output register
	jmw_pkg::sq_tag_t   tag_l;
	jmw_pkg::sq_state_t st_l;

	assign tag_l = sq_tag[jmw_pkg::SQ_STAGES];
	assign st_l = sq_st[jmw_pkg::SQ_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en_o) begin
			res_valid <= sq_v[jmw_pkg::SQ_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			res.weight <= tag_l.use_root ? $signed(st_l.root[31:0]) : $signed(tag_l.w);
			res.active_columns <= tag_l.n;
			res.saturated <= tag_l.sat;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/jmw_checker.sv]
// jmw_checker: port-level checks of the jacobian measure weight core, bound to the top
// depends on jmw_pkg and jacobian_measure_weight_core
`default_nettype none

module jmw_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              res_valid,
	input wire logic                              res_stall,
	input wire jmw_pkg::res_t                     res
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// no active column means a zero weight
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.active_columns == 2'd0 |-> res.weight == 32'sd0 && !res.saturated)
		else $error("nonzero weight with no active column");

	// roots never negative
	a_root_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.active_columns == 2'd1 || res.active_columns == 2'd2)
		|-> !res.weight[31])
		else $error("negative area or length");

	// saturation gives a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.saturated
		|-> $unsigned(res.weight) == jmw_pkg::W_MAX || $unsigned(res.weight) == jmw_pkg::W_MIN)
		else $error("saturated weight is not a range limit");

endmodule

bind jacobian_measure_weight_core jmw_checker u_jmw_checker (.*);

`default_nettype wire
